// File: hw/rtl/mcd_pkg.sv
`timescale 1ns / 1ps

package mcd_pkg;

    localparam int PT_W       = 11;
    localparam int CHAR_W     = 8;
    localparam int DIST_W     = 14;
    localparam int SQ_W       = 22;
    localparam int N_W        = 30;
    localparam int ROOT_STEPS = 15;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_MARK    = 8'd42;
    localparam logic [DIST_W-1:0] DIST_MAX     = 14'h3FFF;

    localparam logic REG_POINT_COL = 1'b0;
    localparam logic REG_POINT_ROW = 1'b1;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic sat;
    } mcd_tag_t;

endpackage

// File: hw/rtl/marked_cell_distance.sv
`timescale 1ns / 1ps
// A word passes through the front registers, the root cells and the output register.
// Throughput: one word per cycle while no output word waits; the 15-cell square
// root chain is fully pipelined. Every stage moves together and stops only while
// the output word waits. Reset is synchronous and active low; it clears the
// counters, the point registers and every valid flag, and no clearing pass follows.
module marked_cell_distance #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] map_char
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,   // [13:0] distance_tenths, zeros above
    output logic [0:0]                  m_tuser,   // [0] row_end
    input  logic                        cfg_wen,
    input  logic                        cfg_index,
    input  logic [mcd_pkg::PT_W-1:0]    cfg_data
);

    localparam int STEPS = mcd_pkg::ROOT_STEPS;

    logic                       adv;
    mcd_pkg::mcd_tag_t          tag_c [STEPS+1];
    logic [mcd_pkg::N_W-1:0]    rem_c [STEPS+1];
    logic [mcd_pkg::N_W-1:0]    root_c [STEPS+1];

    assign s_tready  = adv;
    assign root_c[0] = '0;

    mcd_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tag_o     (tag_c[0]),
        .n_o       (rem_c[0])
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        mcd_sqrt_cell #(
            .BIT_POS (2 * (STEPS - 1 - i))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tag_i   (tag_c[i]),
            .rem_i   (rem_c[i]),
            .root_i  (root_c[i]),
            .tag_o   (tag_c[i+1]),
            .rem_o   (rem_c[i+1]),
            .root_o  (root_c[i+1])
        );
    end

    mcd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_i    (tag_c[STEPS]),
        .rem_i    (rem_c[STEPS]),
        .root_i   (root_c[STEPS]),
        .m_tready (m_tready),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hw/rtl/mcd_front.sv
`timescale 1ns / 1ps

module mcd_front #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         s_tvalid,
    input  logic [mcd_pkg::CHAR_W-1:0]   s_tdata,
    input  logic                         cfg_wen,
    input  logic                         cfg_index,
    input  logic [mcd_pkg::PT_W-1:0]     cfg_data,
    output mcd_pkg::mcd_tag_t            tag_o,
    output logic [mcd_pkg::N_W-1:0]      n_o
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CRW = (CW > RW) ? CW : RW;
    localparam int XW  = ((CRW > mcd_pkg::PT_W) ? CRW : mcd_pkg::PT_W) + 1;
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    logic [mcd_pkg::PT_W-1:0] pcol_reg, prow_reg;
    logic [CW-1:0]            col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;

    mcd_pkg::mcd_tag_t        t1_reg, t1_next, t2_reg, t3_reg;
    logic [mcd_pkg::PT_W-1:0] dx_reg, dy_reg;
    logic [mcd_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    logic [mcd_pkg::N_W-1:0]  n_reg;

    logic                     accept, is_nl, is_mark;
    logic [XW-1:0]            ax, bx, ay, by, ddx, ddy;
    logic [mcd_pkg::SQ_W:0]   sum;

    assign accept  = s_tvalid && adv;
    assign is_nl   = (s_tdata == mcd_pkg::CHAR_NEWLINE);
    assign is_mark = (s_tdata == mcd_pkg::CHAR_MARK);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (is_nl) begin
                col_next = '0;
                if (row_reg < ROW_LAST) begin
                    row_next = row_reg + RW'(1);
                end
            end else if (col_reg < COL_LAST) begin
                col_next = col_reg + CW'(1);
            end
        end

        ax  = XW'(pcol_reg);
        bx  = XW'(col_reg) + XW'(1);
        ay  = XW'(prow_reg);
        by  = XW'(row_reg) + XW'(1);
        ddx = (ax >= bx) ? (ax - bx) : (bx - ax);
        ddy = (ay >= by) ? (ay - by) : (by - ay);

        t1_next.valid   = accept && (is_nl || is_mark);
        t1_next.row_end = is_nl;
        t1_next.sat     = (|ddx[XW-1:mcd_pkg::PT_W]) || (|ddy[XW-1:mcd_pkg::PT_W]);

        sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcol_reg <= '0;
            prow_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
        end else begin
            if (cfg_wen) begin
                if (cfg_index == mcd_pkg::REG_POINT_COL) begin
                    pcol_reg <= cfg_data;
                end else if (cfg_index == mcd_pkg::REG_POINT_ROW) begin
                    prow_reg <= cfg_data;
                end
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv) begin
                t1_reg <= t1_next;
                t2_reg <= t1_reg;
                t3_reg <= t2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg  <= ddx[mcd_pkg::PT_W-1:0];
            dy_reg  <= ddy[mcd_pkg::PT_W-1:0];
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            n_reg   <= (mcd_pkg::N_W'(sum) << 6) + (mcd_pkg::N_W'(sum) << 5)
                     + (mcd_pkg::N_W'(sum) << 2);
        end
    end

    assign tag_o = t3_reg;
    assign n_o   = n_reg;

endmodule

// File: hw/rtl/mcd_sqrt_cell.sv
`timescale 1ns / 1ps

module mcd_sqrt_cell #(
    parameter int BIT_POS = 28
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  mcd_pkg::mcd_tag_t           tag_i,
    input  logic [mcd_pkg::N_W-1:0]     rem_i,
    input  logic [mcd_pkg::N_W-1:0]     root_i,
    output mcd_pkg::mcd_tag_t           tag_o,
    output logic [mcd_pkg::N_W-1:0]     rem_o,
    output logic [mcd_pkg::N_W-1:0]     root_o
);

    localparam logic [mcd_pkg::N_W-1:0] BIT_VAL = mcd_pkg::N_W'(1) << BIT_POS;

    mcd_pkg::mcd_tag_t          tag_reg;
    logic [mcd_pkg::N_W-1:0]    rem_reg, rem_next, root_reg, root_next, trial;

    always_comb begin
        trial = root_i + BIT_VAL;
        if (rem_i >= trial) begin
            rem_next  = rem_i - trial;
            root_next = (root_i >> 1) + BIT_VAL;
        end else begin
            rem_next  = rem_i;
            root_next = root_i >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign tag_o  = tag_reg;
    assign rem_o  = rem_reg;
    assign root_o = root_reg;

endmodule

// File: hw/rtl/mcd_out.sv
`timescale 1ns / 1ps

module mcd_out (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mcd_pkg::mcd_tag_t           tag_i,
    input  logic [mcd_pkg::N_W-1:0]     rem_i,
    input  logic [mcd_pkg::N_W-1:0]     root_i,
    input  logic                        m_tready,
    output logic                        adv,
    output logic                        m_tvalid,
    output logic [15:0]                 m_tdata,
    output logic [0:0]                  m_tuser
);

    localparam int RT_W = mcd_pkg::ROOT_STEPS;

    logic                       valid_reg;
    logic [mcd_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                       row_end_reg;
    logic [RT_W:0]              rounded;

    assign adv = !valid_reg || m_tready;

    always_comb begin
        rounded = {1'b0, root_i[RT_W-1:0]} + (RT_W+1)'(rem_i > root_i);
        if (tag_i.row_end) begin
            dist_next = '0;
        end else if (tag_i.sat || (|rounded[RT_W:mcd_pkg::DIST_W])) begin
            dist_next = mcd_pkg::DIST_MAX;
        end else begin
            dist_next = rounded[mcd_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= tag_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tag_i.valid) begin
            dist_reg    <= dist_next;
            row_end_reg <= tag_i.row_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, dist_reg};
    assign m_tuser  = row_end_reg;

endmodule

// File: hw/rtl/mcd_checker.sv
`timescale 1ns / 1ps

module mcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A result word that is not taken holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // The whole pipeline stops while the output word waits.
    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Row-end markers carry a zero distance.
    a_row_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("row end with nonzero distance");

    // The padding bits above the distance stay clear.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:14] == 2'b00)
        else $error("padding bits set");

    // No word leaves the block right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind marked_cell_distance mcd_checker u_mcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/marked_cell_distance_tb.sv
`timescale 1ns / 1ps

module marked_cell_distance_tb;

    localparam int MAX_COLS      = 1024;
    localparam int MAX_ROWS      = 1024;
    localparam int SETTLE_CYCLES = 30;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [mcd_pkg::DIST_W-1:0] tenths;
        logic                       row_end;
    } dist_word_t;

    class distance_scoreboard;
        logic [mcd_pkg::PT_W-1:0] point_col;
        logic [mcd_pkg::PT_W-1:0] point_row;
        logic [mcd_pkg::PT_W-1:0] col_count;
        logic [mcd_pkg::PT_W-1:0] row_count;
        dist_word_t               pending_q[$];
        int                       errors;

        function new();
            point_col = '0;
            point_row = '0;
            col_count = '0;
            row_count = '0;
            errors    = 0;
        endfunction

        function void set_point(logic idx, logic [mcd_pkg::PT_W-1:0] value);
            if (idx == mcd_pkg::REG_POINT_COL) begin
                point_col = value;
            end else begin
                point_row = value;
            end
        endfunction

        function logic [mcd_pkg::DIST_W-1:0] cell_tenths();
            longint unsigned dx, dy, n, rem, root, probe, d;
            longint unsigned cell_col, cell_row;
            cell_col = longint'(col_count) + 1;
            cell_row = longint'(row_count) + 1;
            dx = (point_col >= cell_col) ? point_col - cell_col : cell_col - point_col;
            dy = (point_row >= cell_row) ? point_row - cell_row : cell_row - point_row;
            n = 100 * (dx * dx + dy * dy);
            rem = n;
            root = 0;
            probe = 64'd1 << 62;
            while (probe > rem) probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= root + probe) begin
                    rem = rem - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            d = (n <= root * root + root) ? root : root + 1;
            if (d > mcd_pkg::DIST_MAX) d = mcd_pkg::DIST_MAX;
            return d[mcd_pkg::DIST_W-1:0];
        endfunction

        function void note_char(logic [mcd_pkg::CHAR_W-1:0] c);
            dist_word_t w;
            if (c == mcd_pkg::CHAR_NEWLINE) begin
                col_count = '0;
                if (row_count < MAX_ROWS - 1) row_count = row_count + 1'b1;
                w.tenths  = '0;
                w.row_end = 1'b1;
                pending_q = {pending_q, w};
            end else begin
                if (c == mcd_pkg::CHAR_MARK) begin
                    w.tenths  = cell_tenths();
                    w.row_end = 1'b0;
                    pending_q = {pending_q, w};
                end
                if (col_count < MAX_COLS - 1) col_count = col_count + 1'b1;
            end
        endfunction

        function void check_word(logic [15:0] data, logic row_end);
            dist_word_t w;
            if (pending_q.size() == 0) begin
                $error("unexpected word: distance_tenths %0d row_end %0d",
                       data[mcd_pkg::DIST_W-1:0], row_end);
                errors++;
                return;
            end
            w = pending_q.pop_front();
            if (data[mcd_pkg::DIST_W-1:0] !== w.tenths) begin
                $error("distance_tenths: expected %0d, actual %0d",
                       w.tenths, data[mcd_pkg::DIST_W-1:0]);
                errors++;
            end
            if (row_end !== w.row_end) begin
                $error("row_end: expected %0d, actual %0d", w.row_end, row_end);
                errors++;
            end
            if (data[15:mcd_pkg::DIST_W] !== '0) begin
                $error("tdata padding: expected 0, actual %0d", data[15:mcd_pkg::DIST_W]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [7:0]               s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [15:0]              m_tdata;
    logic [0:0]               m_tuser;
    logic                     cfg_wen   = 1'b0;
    logic                     cfg_index = 1'b0;
    logic [mcd_pkg::PT_W-1:0] cfg_data  = '0;

    int                idle_pct     = 0;
    int                stall_pct    = 0;
    int                quiet_cycles = 0;

    distance_scoreboard sb = new();

    marked_cell_distance #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_char(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser[0]);
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[marked_cell_distance] ERROR");
        $finish;
    end

    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_point(input logic [mcd_pkg::PT_W-1:0] col,
                               input logic [mcd_pkg::PT_W-1:0] row);
        cfg_wen   <= 1'b1;
        cfg_index <= mcd_pkg::REG_POINT_COL;
        cfg_data  <= col;
        @(posedge aclk);
        sb.set_point(mcd_pkg::REG_POINT_COL, col);
        cfg_index <= mcd_pkg::REG_POINT_ROW;
        cfg_data  <= row;
        @(posedge aclk);
        sb.set_point(mcd_pkg::REG_POINT_ROW, row);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == mcd_pkg::CHAR_NEWLINE);
        return c;
    endfunction

    task automatic send_map(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_char(8'($urandom_range(255)));
                sent++;
            end else begin
                len = $urandom_range(30);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 30) begin
                        send_char(mcd_pkg::CHAR_MARK);
                    end else if (pick < 40) begin
                        send_char(plain_char());
                    end else begin
                        send_char(".");
                    end
                end
                send_char(mcd_pkg::CHAR_NEWLINE);
                sent += len + 1;
            end
        end
    endtask

    initial begin
        logic [7:0] opening[12];
        opening = '{mcd_pkg::CHAR_MARK, 8'h00, 8'hFF, mcd_pkg::CHAR_MARK,
                    mcd_pkg::CHAR_NEWLINE, mcd_pkg::CHAR_NEWLINE, mcd_pkg::CHAR_MARK,
                    8'd11, 8'd9, 8'd43, 8'd41, mcd_pkg::CHAR_MARK};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) send_char(opening[i]);
        settle();
        write_point(11'd2047, 11'd2047);
        send_char(mcd_pkg::CHAR_NEWLINE);
        send_char(mcd_pkg::CHAR_MARK);
        send_char(mcd_pkg::CHAR_MARK);
        settle();
        write_point(11'd1, 11'd4);
        send_char(mcd_pkg::CHAR_MARK);
        send_char(mcd_pkg::CHAR_MARK);
        send_char(mcd_pkg::CHAR_NEWLINE);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            unique case (phase)
                0: write_point(11'd1, 11'd1);
                1: write_point(11'd1024, 11'd1024);
                2: write_point(11'd2047, 11'd2047);
                3: write_point(11'd2047, 11'd0);
                4: write_point(11'd0, 11'd2047);
                default: write_point(11'($urandom_range(1024)), 11'($urandom_range(1024)));
            endcase
            unique case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 58; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 58; end
                default: begin idle_pct = 15; stall_pct <= 15; end
            endcase
            send_map(30);
            if (phase == 1) settle();
            send_map(25);
            settle();
        end

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("[marked_cell_distance] OK");
        end else begin
            $display("[marked_cell_distance] ERROR");
        end
        $finish;
    end

endmodule
